>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication that must hold in the next cycle, checked also through reset.
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/pgc_pkg.sv
// Types, constants and elaboration-time tables for the gamma correction unit.
// Depends on nothing.
package pgc_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int FRAC_BITS  = 28;
  localparam int N_W        = $clog2(PIXEL_BITS);
  localparam int M_W        = 31;
  localparam int LOG_W      = N_W + FRAC_BITS;
  localparam int G_W        = 16;
  localparam int PROD_W     = LOG_W + G_W;
  localparam int E_W        = PROD_W - 12;
  localparam int IP_W       = E_W - FRAC_BITS;
  localparam int V_W        = 33;
  localparam int R_W        = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA        = 2'd1;

  localparam logic [15:0] MAX_NARROW = 16'h00FF;
  localparam logic [15:0] MAX_WIDE   = 16'((64'd1 << PIXEL_BITS) - 64'd1);

  typedef struct packed {
    logic [15:0] pixel_in;
    logic        frame_end_in;
  } pgc_in_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        frame_end_out;
  } pgc_out_t;

  typedef struct packed {
    logic        frame_end;
    logic        spec;
    logic [15:0] spec_val;
  } side_t;

  typedef logic [R_W-1:0] root_tab_t [FRAC_BITS+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bt;
    a   = a_in;
    res = 64'd0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (a >= res + bt) begin
        a   = a - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Entry k holds 2^(-2^-k) in Q.32; entry 0 unused.
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] r;
    t[0] = '0;
    r = isqrt64(64'd1 << 63);
    for (int k = 1; k <= FRAC_BITS; k++) begin
      t[k] = R_W'(r);
      r = isqrt64(r << 32);
    end
    return t;
  endfunction

  function automatic logic [LOG_W-1:0] log2_q28(input logic [63:0] v);
    int          n;
    logic [63:0] m;
    logic [63:0] frac;
    n    = 0;
    frac = 64'd0;
    for (int b = 0; b < 64; b++) begin
      if (v[b]) n = b;
    end
    m = (n <= 30) ? (v << (30 - n)) : (v >> (n - 30));
    for (int i = 1; i <= FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | (64'd1 << (FRAC_BITS - i));
      end
    end
    return LOG_W'((64'(n) << FRAC_BITS) | frac);
  endfunction

  localparam root_tab_t        ROOTS      = build_roots();
  localparam logic [LOG_W-1:0] LOG_NARROW = log2_q28(64'(MAX_NARROW));
  localparam logic [LOG_W-1:0] LOG_WIDE   = log2_q28(64'(MAX_WIDE));

endpackage

>>> design/pixel_gamma_correction_unit.sv
// Throughput one pixel per cycle while the output is not stalled; the pipe holds
// 28 log2 squaring stages and 28 root multiply stages, one multiplier each.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets
// pixel_format = 8-bit and gamma_exponent = 1.0.
module pixel_gamma_correction_unit import pgc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pgc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pgc_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic        fmt_r;
  logic [15:0] gamma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= 1'b0;
      gamma_r <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: fmt_r   <= cfg_wdata[0];
        REG_GAMMA:        gamma_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipe advances together unless the output holds an untaken result.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [15:0] maxv;
  assign maxv = fmt_r ? MAX_WIDE : MAX_NARROW;

  // ---------------- Entry stage: mask, special cases, normalize ----------------
  logic [15:0]    x_m;
  logic [N_W-1:0] n_a;
  logic [M_W-1:0] m_a;
  side_t          side_a;

  always_comb begin
    x_m = in_data.pixel_in & maxv;
    n_a = '0;
    for (int b = 0; b < PIXEL_BITS; b++) begin
      if (x_m[b]) n_a = N_W'(b);
    end
    m_a = M_W'(x_m) << (5'(M_W - 1) - 5'(n_a));
    side_a.frame_end = in_data.frame_end_in;
    // Zero pixel, full scale and zero exponent bypass the arithmetic.
    if (x_m == 16'd0) begin
      side_a.spec     = 1'b1;
      side_a.spec_val = (gamma_r == 16'd0) ? maxv : 16'd0;
    end else if (x_m >= maxv || gamma_r == 16'd0) begin
      side_a.spec     = 1'b1;
      side_a.spec_val = maxv;
    end else begin
      side_a.spec     = 1'b0;
      side_a.spec_val = 16'd0;
    end
  end

  // ---------------- log2 stages: index 0 is the entry register ----------------
  logic                 lg_vld_r  [FRAC_BITS+1];
  logic [M_W-1:0]       lg_m_r    [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] lg_f_r    [FRAC_BITS+1];
  logic [N_W-1:0]       lg_n_r    [FRAC_BITS+1];
  side_t                lg_side_r [FRAC_BITS+1];

  logic [2*M_W-1:0]     sq   [FRAC_BITS+1];
  logic [M_W:0]         sqs  [FRAC_BITS+1];
  logic [M_W-1:0]       m_nxt [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] f_nxt [FRAC_BITS+1];

  always_comb begin
    sq[0]    = '0;
    sqs[0]   = '0;
    m_nxt[0] = m_a;
    f_nxt[0] = '0;
    for (int i = 1; i <= FRAC_BITS; i++) begin
      sq[i]  = (2*M_W)'(lg_m_r[i-1]) * (2*M_W)'(lg_m_r[i-1]);
      sqs[i] = sq[i][2*M_W-1:M_W-1];
      f_nxt[i] = lg_f_r[i-1];
      // A square at or above 2.0 yields the next fraction bit; halve it.
      if (sqs[i][M_W]) begin
        m_nxt[i] = sqs[i][M_W:1];
        f_nxt[i][FRAC_BITS-i] = 1'b1;
      end else begin
        m_nxt[i] = sqs[i][M_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= FRAC_BITS; i++) lg_vld_r[i] <= 1'b0;
    end else if (adv) begin
      lg_vld_r[0] <= in_valid;
      for (int i = 1; i <= FRAC_BITS; i++) lg_vld_r[i] <= lg_vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_m_r[0]    <= m_nxt[0];
      lg_f_r[0]    <= f_nxt[0];
      lg_n_r[0]    <= n_a;
      lg_side_r[0] <= side_a;
      for (int i = 1; i <= FRAC_BITS; i++) begin
        lg_m_r[i]    <= m_nxt[i];
        lg_f_r[i]    <= f_nxt[i];
        lg_n_r[i]    <= lg_n_r[i-1];
        lg_side_r[i] <= lg_side_r[i-1];
      end
    end
  end

  // ---------------- Distance from full scale, then exponent product ----------------
  logic [LOG_W-1:0]  lx;
  logic [LOG_W-1:0]  lm;
  logic [LOG_W-1:0]  l_nxt;
  logic              l_vld_r;
  logic [LOG_W-1:0]  l_r;
  side_t             l_side_r;
  logic [PROD_W-1:0] lg_prod;

  assign lx      = {lg_n_r[FRAC_BITS], lg_f_r[FRAC_BITS]};
  assign lm      = fmt_r ? LOG_WIDE : LOG_NARROW;
  assign l_nxt   = (lm > lx) ? (lm - lx) : '0;
  assign lg_prod = PROD_W'(l_r) * PROD_W'(gamma_r);

  // ---------------- 2^-E stages: index 0 holds E and v = 1.0 ----------------
  logic                 ex_vld_r  [FRAC_BITS+1];
  logic [V_W-1:0]       ex_v_r    [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] ex_f_r    [FRAC_BITS+1];
  logic [IP_W-1:0]      ex_ip_r   [FRAC_BITS+1];
  side_t                ex_side_r [FRAC_BITS+1];

  logic [V_W+R_W-1:0] vp    [FRAC_BITS+1];
  logic [V_W-1:0]     v_nxt [FRAC_BITS+1];

  always_comb begin
    vp[0]    = '0;
    v_nxt[0] = V_W'(64'd1 << 32);
    for (int k = 1; k <= FRAC_BITS; k++) begin
      vp[k] = (V_W+R_W)'(ex_v_r[k-1]) * (V_W+R_W)'(ROOTS[k]);
      v_nxt[k] = ex_f_r[k-1][FRAC_BITS-k] ? vp[k][V_W+R_W-1:R_W] : ex_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r <= 1'b0;
      for (int k = 0; k <= FRAC_BITS; k++) ex_vld_r[k] <= 1'b0;
    end else if (adv) begin
      l_vld_r     <= lg_vld_r[FRAC_BITS];
      ex_vld_r[0] <= l_vld_r;
      for (int k = 1; k <= FRAC_BITS; k++) ex_vld_r[k] <= ex_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_r          <= l_nxt;
      l_side_r     <= lg_side_r[FRAC_BITS];
      ex_v_r[0]    <= v_nxt[0];
      ex_f_r[0]    <= lg_prod[12 +: FRAC_BITS];
      ex_ip_r[0]   <= lg_prod[12+FRAC_BITS +: IP_W];
      ex_side_r[0] <= l_side_r;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        ex_v_r[k]    <= v_nxt[k];
        ex_f_r[k]    <= ex_f_r[k-1];
        ex_ip_r[k]   <= ex_ip_r[k-1];
        ex_side_r[k] <= ex_side_r[k-1];
      end
    end
  end

  // ---------------- Integer shift, then scale, round and clamp ----------------
  logic           s_vld_r;
  logic [V_W-1:0] s_v_r;
  side_t          s_side_r;
  logic [V_W-1:0] s_nxt;

  assign s_nxt = (ex_ip_r[FRAC_BITS] >= IP_W'(32)) ? '0 :
                 (ex_v_r[FRAC_BITS] >> ex_ip_r[FRAC_BITS][5:0]);

  logic [V_W+15:0] sc;
  logic [16:0]     rnd;
  logic [15:0]     res;

  always_comb begin
    sc  = (V_W+16)'(maxv) * (V_W+16)'(s_v_r) + (V_W+16)'(64'd1 << 31);
    rnd = sc[V_W+15:32];
    res = (rnd > 17'(maxv)) ? maxv : rnd[15:0];
  end

  logic     o_vld_r;
  pgc_out_t o_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      s_vld_r <= ex_vld_r[FRAC_BITS];
      o_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_v_r    <= s_nxt;
      s_side_r <= ex_side_r[FRAC_BITS];
      o_data_r.pixel_out     <= s_side_r.spec ? s_side_r.spec_val : res;
      o_data_r.frame_end_out <= s_side_r.frame_end;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule

>>> design/pgc_checker.sv
// Port-level checker for the gamma correction unit, bound to its top level.
// Depends on pgc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pgc_checker import pgc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pgc_out_t out_data
);

  // A result waiting for transfer holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n && out_valid && !out_ready, out_valid && $stable(out_data))
  // Input is taken exactly when the output side can advance.
  `ASSERT_SAME(a_ready_follow, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
  // Reset empties the pipeline.
  `ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind pixel_gamma_correction_unit pgc_checker u_pgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pixel gamma correction unit.
// Depends on pgc_pkg and pixel_gamma_correction_unit; predicts each pixel in place.
module tb_top;
  import pgc_pkg::*;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 70;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pgc_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pgc_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Testbench copy of the configuration registers.
  logic        fmt_wide;
  logic [15:0] gamma_q412;

  logic [31:0] root_q32 [FRAC_BITS+1];
  pgc_out_t    pending_pixels [$];
  int          fail_count = 0;
  int          pixels_sent = 0;
  int          pixels_checked = 0;
  int          cfg_writes = 0;
  bit          idle_enable = 1'b1;

  always #6 clk = ~clk;

  pixel_gamma_correction_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [63:0] int_sqrt(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bt;
    a = a_in;
    res = 0;
    bt = 64'd1 << 62;
    while (bt != 0) begin
      if (a >= res + bt) begin
        a = a - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // log2 in Q.28 by repeated squaring of the normalized mantissa.
  function automatic logic [63:0] log2_fixed(input logic [63:0] v);
    int          top;
    logic [63:0] mant;
    logic [63:0] frac;
    top = 0;
    frac = 0;
    for (int b = 0; b < 64; b++) if (v[b]) top = b;
    mant = v << (30 - top);
    for (int i = 1; i <= FRAC_BITS; i++) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac[FRAC_BITS - i] = 1'b1;
      end
    end
    return (64'(top) << FRAC_BITS) | frac;
  endfunction

  function automatic pgc_out_t corrected_pixel(input pgc_in_t item);
    logic [63:0] maxv, x, lx, lm, l, e, ip, fp, v, res;
    pgc_out_t    o;
    maxv = fmt_wide ? 64'd65535 : 64'd255;
    x = item.pixel_in & maxv;
    if (x == 0) begin
      res = (gamma_q412 == 0) ? maxv : 0;
    end else if (x >= maxv || gamma_q412 == 0) begin
      res = maxv;
    end else begin
      lx = log2_fixed(x);
      lm = log2_fixed(maxv);
      l = (lm > lx) ? lm - lx : 0;
      e = (l * gamma_q412) >> 12;
      ip = e >> FRAC_BITS;
      fp = e & ((64'd1 << FRAC_BITS) - 1);
      v = 64'd1 << 32;
      for (int k = 1; k <= FRAC_BITS; k++)
        if (fp[FRAC_BITS - k]) v = (v * root_q32[k]) >> 32;
      v = (ip >= 32) ? 0 : (v >> ip);
      res = (maxv * v + (64'd1 << 31)) >> 32;
      if (res > maxv) res = maxv;
    end
    o.pixel_out = res[15:0];
    o.frame_end_out = item.frame_end_in;
    return o;
  endfunction

  // Output side: stall in random bursts unless idling is off.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Compare every result transfer with the oldest pending pixel.
  always @(posedge clk) begin
    pgc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_data.pixel_out !== want.pixel_out) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   want.pixel_out, out_data.pixel_out);
          fail_count++;
        end
        if (out_data.frame_end_out !== want.frame_end_out) begin
          $display("%0t: frame_end_out expected %0b actual %0b", $time,
                   want.frame_end_out, out_data.frame_end_out);
          fail_count++;
        end
      end
    end
  end

  // Drive one pixel and hold it until its transfer; record its prediction.
  task automatic send_pixel(input logic [15:0] pix, input logic fe);
    int n;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_data.pixel_in = pix;
    in_data.frame_end_in = fe;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(corrected_pixel(in_data));
    pixels_sent++;
    @(negedge clk);
  endtask

  // Let every pending pixel come out, then let the pipe empty fully.
  task automatic drain_pipe();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    drain_pipe();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_PIXEL_FORMAT) fmt_wide = val[0];
    else if (idx == REG_GAMMA) gamma_q412 = val;
    cfg_writes++;
  endtask

  task automatic test_reset_defaults();
    send_pixel(16'd0, 1'b0);
    send_pixel(16'd255, 1'b1);
    send_pixel(16'hFF80, 1'b0);   // upper bits dropped in 8-bit format
    send_pixel(16'd1, 1'b0);
  endtask

  task automatic test_directed_extremes();
    write_reg(REG_GAMMA, 16'd0);  // zero exponent: all pixels full scale
    send_pixel(16'd0, 1'b1);
    send_pixel(16'd77, 1'b0);
    write_reg(REG_GAMMA, 16'hFFFF);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'd1, 1'b1);
    send_pixel(16'd254, 1'b0);
    send_pixel(16'd255, 1'b0);
    write_reg(REG_PIXEL_FORMAT, 16'hFFFF);
    send_pixel(16'd1, 1'b0);
    send_pixel(16'd65534, 1'b1);
    send_pixel(16'd65535, 1'b0);
    write_reg(REG_GAMMA, 16'd2048);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'd1, 1'b0);
    send_pixel(16'h8000, 1'b1);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
  endtask

  task automatic test_unused_index();
    write_reg(REG_UNUSED, 16'h1234);
    write_reg(REG_SPARE, 16'h0000);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'h00C3, 1'b0);
  endtask

  task automatic test_random_phases();
    logic [15:0] pix;
    logic [15:0] g;
    int          sel;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: g = 16'd0;
        1: g = 16'hFFFF;
        2: g = 16'd4096;
        3: g = 16'd1;
        default: g = 16'($urandom_range(0, 65535));
      endcase
      if (ph == 7) idle_enable = 1'b0;  // final stretch at full rate
      write_reg(REG_PIXEL_FORMAT, 16'($urandom_range(0, 1)));
      write_reg(REG_GAMMA, g);
      for (int i = 0; i < 115; i++) begin
        sel = $urandom_range(0, 9);
        if (sel < 5) pix = 16'($urandom());
        else if (sel < 7) pix = 16'($urandom_range(0, 3));
        else if (sel < 9) pix = (fmt_wide ? 16'hFFFF : 16'h00FF)
                                - 16'($urandom_range(0, 2));
        else pix = 16'($urandom_range(0, 255));
        send_pixel(pix, 1'($urandom()));
      end
    end
  endtask

  initial begin
    logic [63:0] r;
    r = int_sqrt(64'd1 << 63);
    root_q32[0] = 0;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      root_q32[k] = r[31:0];
      r = int_sqrt(r << 32);
    end
    fmt_wide = 1'b0;
    gamma_q412 = 16'd4096;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_unused_index();
    test_random_phases();
    drain_pipe();
    $display("Run covered %0d pixels, %0d checked, %0d register writes,",
             pixels_sent, pixels_checked, cfg_writes);
    $display("both formats and exponents from zero to full range.");
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_pixels.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
